// ===== hdl/acp_pkg.sv =====
package acp_pkg;

    localparam logic [31:0] PREFIX_RESET = 32'h2f2f543a;  // "//T:"
    localparam int          QUEUE_DEPTH  = 2;

    typedef enum logic [3:0] {
        PH_PREFIX,
        PH_LOOK_NAME,
        PH_NAME,
        PH_LOOK_PARAM,
        PH_PARAM,
        PH_ENTRY,
        PH_KEY,
        PH_VALUE,
        PH_FINAL
    } acp_phase_t;

    localparam logic [3:0] EV_NONE       = 4'd0;
    localparam logic [3:0] EV_BEGIN      = 4'd1;
    localparam logic [3:0] EV_NAME_BYTE  = 4'd2;
    localparam logic [3:0] EV_ENTRY_BYTE = 4'd3;
    localparam logic [3:0] EV_ENTRY_END  = 4'd4;
    localparam logic [3:0] EV_KEY_BYTE   = 4'd5;
    localparam logic [3:0] EV_VALUE_BYTE = 4'd6;
    localparam logic [3:0] EV_PAIR_END   = 4'd7;
    localparam logic [3:0] EV_HEADER_END = 4'd8;

    localparam logic [3:0] ERR_NONE        = 4'd0;
    localparam logic [3:0] ERR_STRAY_CR    = 4'd1;
    localparam logic [3:0] ERR_BAD_NAME    = 4'd2;
    localparam logic [3:0] ERR_BAD_PARAM   = 4'd3;
    localparam logic [3:0] ERR_UNKNOWN     = 4'd4;
    localparam logic [3:0] ERR_BAD_ENTRY   = 4'd5;
    localparam logic [3:0] ERR_DUPLICATE   = 4'd6;
    localparam logic [3:0] ERR_BAD_KEY     = 4'd7;
    localparam logic [3:0] ERR_NO_VERTEX   = 4'd8;

    localparam logic [1:0] KW_DEFINE = 2'd0;
    localparam logic [1:0] KW_META   = 2'd1;
    localparam logic [1:0] KW_VS     = 2'd2;
    localparam logic [1:0] KW_PS     = 2'd3;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_UNDER = 8'h5f;

    // classified byte, front to back
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       blank;
        logic       ident;
        logic       cr;
        logic       lf;
        logic       colon;
        logic       eq;
    } acp_item_t;

    typedef struct packed {
        logic [3:0]  ev;
        logic [7:0]  ch;
        logic        stage;
        logic        pair_kind;
        logic [3:0]  err;
        logic [31:0] line;
    } acp_result_t;

    function automatic logic [2:0] kw_len(input logic [1:0] k);
        logic [2:0] len;
        unique case (k)
            KW_DEFINE: len = 3'd6;
            KW_META:   len = 3'd4;
            KW_VS:     len = 3'd2;
            KW_PS:     len = 3'd2;
            default:   len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        unique case (k)
            KW_DEFINE:
            begin
                unique case (pos)
                    3'd0:    c = 8'h64;  // d
                    3'd1:    c = 8'h65;  // e
                    3'd2:    c = 8'h66;  // f
                    3'd3:    c = 8'h69;  // i
                    3'd4:    c = 8'h6e;  // n
                    3'd5:    c = 8'h65;  // e
                    default: c = 8'h00;
                endcase
            end
            KW_META:
            begin
                unique case (pos)
                    3'd0:    c = 8'h6d;  // m
                    3'd1:    c = 8'h65;  // e
                    3'd2:    c = 8'h74;  // t
                    3'd3:    c = 8'h61;  // a
                    default: c = 8'h00;
                endcase
            end
            KW_VS:
            begin
                unique case (pos)
                    3'd0:    c = 8'h76;  // v
                    3'd1:    c = 8'h73;  // s
                    default: c = 8'h00;
                endcase
            end
            KW_PS:
            begin
                unique case (pos)
                    3'd0:    c = 8'h70;  // p
                    3'd1:    c = 8'h73;  // s
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/annotation_comment_parser_core.sv =====
// Path: an accepted byte is written into the queue, then parsed into the output
// register when the queue pops it, and its result is transferred from that
// register on the m_tvalid/m_tready handshake.
// Throughput: one byte per cycle; the parser pops the queue whenever its output
// register is empty or being taken, so only output backpressure stalls input.
// Reset (rst_n, async, active low) clears parser state, the queue and the
// output valid, and sets the prefix register to "//T:".
module annotation_comment_parser_core
#(
    parameter int QUEUE_DEPTH = acp_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,    // prefix_word

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] byte_in
    input  logic        s_tlast,     // final_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,     // [7:0] char_out, [11:8] error, [43:12] line_number
    output logic [5:0]  m_tuser      // [3:0] event_res, [4] stage, [5] pair_kind
);

    logic                 q_full;
    logic                 push;
    acp_pkg::acp_item_t   push_item;
    logic                 q_valid;
    acp_pkg::acp_item_t   q_item;
    logic                 pop;
    acp_pkg::acp_result_t res;

    assign cfg_ready = 1'b1;

    acp_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .item     (push_item)
    );

    acp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (q_valid),
        .head_item  (q_item)
    );

    acp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {4'b0000, res.line, res.err, res.ch};
    assign m_tuser = {res.pair_kind, res.stage, res.ev};

endmodule

// ===== hdl/acp_front.sv =====
module acp_front
(
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] byte_in
    input  logic              s_tlast,   // final_byte
    input  logic              q_full,
    output logic              push,
    output acp_pkg::acp_item_t item
);

    logic [7:0] c;

    assign c        = s_tdata;
    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    always_comb
    begin
        item.data  = c;
        item.fin   = s_tlast;
        item.blank = (c == acp_pkg::CH_SPACE) || (c == acp_pkg::CH_TAB);
        item.ident = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
                     (c >= 8'h61 && c <= 8'h7a) || (c == acp_pkg::CH_UNDER);
        item.cr    = (c == acp_pkg::CH_CR);
        item.lf    = (c == acp_pkg::CH_LF);
        item.colon = (c == acp_pkg::CH_COLON);
        item.eq    = (c == acp_pkg::CH_EQ);
    end

endmodule

// ===== hdl/acp_queue.sv =====
module acp_queue
#(
    parameter int DEPTH = acp_pkg::QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  acp_pkg::acp_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output acp_pkg::acp_item_t head_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    acp_pkg::acp_item_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== hdl/acp_back.sv =====
module acp_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [31:0]          cfg_data,
    input  logic                 q_valid,
    input  acp_pkg::acp_item_t   q_item,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output acp_pkg::acp_result_t out_res
);

    acp_pkg::acp_phase_t phase_reg, phase_next;
    logic [31:0] prefix_reg;
    logic [31:0] recent_reg, recent_next;
    logic [31:0] line_reg, line_next;
    logic [3:0]  kw_match_reg, kw_match_next;
    logic [2:0]  kw_len_reg, kw_len_next;
    logic [1:0]  kw_sel_reg, kw_sel_next;
    logic        vertex_reg, vertex_next;
    logic        frag_reg, frag_next;
    logic        carriage_reg, carriage_next;
    logic [3:0]  err_latched_reg, err_latched_next;
    logic        out_valid_reg;
    acp_pkg::acp_result_t out_reg;

    logic [7:0]  c;
    logic        parse_en;
    logic [31:0] recent_upd;
    logic [3:0]  base_match, upd_match;
    logic [2:0]  base_len, upd_len;
    logic        found_ok;
    logic [1:0]  found_k;
    logic        sel_ps;
    logic        dup;

    logic [3:0]  err;
    logic [3:0]  ev;
    logic [7:0]  ch;
    logic        stg;
    logic        pk;

    assign c         = q_item.data;
    assign pop       = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    // byte goes to the parser unless it is a CR or the CR check fails
    assign parse_en   = !q_item.cr && !(carriage_reg && !q_item.lf);
    assign recent_upd = q_item.blank ? recent_reg : {recent_reg[23:0], c};
    assign sel_ps     = (kw_sel_reg == acp_pkg::KW_PS);
    assign dup        = sel_ps ? frag_reg : vertex_reg;

    // keyword candidates; a new parameter restarts them
    always_comb
    begin
        base_match = (phase_reg == acp_pkg::PH_LOOK_PARAM) ? 4'hf : kw_match_reg;
        base_len   = (phase_reg == acp_pkg::PH_LOOK_PARAM) ? 3'd0 : kw_len_reg;
        for (int k = 0; k < 4; k++)
        begin
            upd_match[k] = base_match[k] && (base_len < acp_pkg::kw_len(2'(k))) &&
                           (acp_pkg::kw_char(2'(k), base_len) == c);
        end
        upd_len = (base_len < 3'd7) ? base_len + 3'd1 : base_len;
    end

    always_comb
    begin
        found_ok = 1'b0;
        found_k  = acp_pkg::KW_DEFINE;
        for (int k = 0; k < 4; k++)
        begin
            if (kw_match_reg[k] && (acp_pkg::kw_len(2'(k)) == kw_len_reg))
            begin
                found_ok = 1'b1;
                found_k  = 2'(k);
            end
        end
    end

    // per-byte result and error
    always_comb
    begin
        err = acp_pkg::ERR_NONE;
        ev  = acp_pkg::EV_NONE;
        ch  = 8'h00;
        stg = 1'b0;
        pk  = 1'b0;
        if (err_latched_reg == acp_pkg::ERR_NONE)
        begin
            if (q_item.cr)
            begin
                if (carriage_reg || q_item.fin)
                    err = acp_pkg::ERR_STRAY_CR;
            end
            else if (!parse_en)
            begin
                err = acp_pkg::ERR_STRAY_CR;
            end
            else
            begin
                unique case (phase_reg)
                    acp_pkg::PH_PREFIX:
                    begin
                        if (recent_upd == prefix_reg)
                            ev = acp_pkg::EV_BEGIN;
                    end
                    acp_pkg::PH_LOOK_NAME, acp_pkg::PH_NAME:
                    begin
                        if (q_item.ident)
                        begin
                            ev = acp_pkg::EV_NAME_BYTE;
                            ch = c;
                        end
                        else if (!q_item.blank)
                            err = acp_pkg::ERR_BAD_NAME;
                    end
                    acp_pkg::PH_LOOK_PARAM:
                    begin
                        if (!q_item.ident && !q_item.lf && !q_item.blank)
                            err = acp_pkg::ERR_BAD_PARAM;
                    end
                    acp_pkg::PH_PARAM:
                    begin
                        if (q_item.colon)
                        begin
                            if (!found_ok)
                                err = acp_pkg::ERR_UNKNOWN;
                        end
                        else if (!q_item.ident)
                            err = acp_pkg::ERR_BAD_PARAM;
                    end
                    acp_pkg::PH_ENTRY:
                    begin
                        stg = sel_ps;
                        if (q_item.ident)
                        begin
                            ev = acp_pkg::EV_ENTRY_BYTE;
                            ch = c;
                        end
                        else if (q_item.blank || q_item.lf)
                        begin
                            if (dup)
                                err = acp_pkg::ERR_DUPLICATE;
                            else
                                ev = acp_pkg::EV_ENTRY_END;
                        end
                        else
                            err = acp_pkg::ERR_BAD_ENTRY;
                    end
                    acp_pkg::PH_KEY:
                    begin
                        if (q_item.ident)
                        begin
                            ev = acp_pkg::EV_KEY_BYTE;
                            ch = c;
                            pk = (kw_sel_reg == acp_pkg::KW_META);
                        end
                        else if (!q_item.eq)
                            err = acp_pkg::ERR_BAD_KEY;
                    end
                    acp_pkg::PH_VALUE:
                    begin
                        pk = (kw_sel_reg == acp_pkg::KW_META);
                        if (!q_item.blank && !q_item.lf)
                        begin
                            ev = acp_pkg::EV_VALUE_BYTE;
                            ch = c;
                        end
                        else
                            ev = acp_pkg::EV_PAIR_END;
                    end
                    default:
                    begin
                        if (!vertex_reg)
                            err = acp_pkg::ERR_NO_VERTEX;
                        else
                            ev = acp_pkg::EV_HEADER_END;
                    end
                endcase
            end
            if (err != acp_pkg::ERR_NONE)
            begin
                ev  = acp_pkg::EV_NONE;
                ch  = 8'h00;
                stg = 1'b0;
                pk  = 1'b0;
            end
        end
    end

    // parser state update
    always_comb
    begin
        phase_next       = phase_reg;
        recent_next      = recent_reg;
        line_next        = line_reg;
        kw_match_next    = kw_match_reg;
        kw_len_next      = kw_len_reg;
        kw_sel_next      = kw_sel_reg;
        vertex_next      = vertex_reg;
        frag_next        = frag_reg;
        carriage_next    = carriage_reg;
        err_latched_next = err_latched_reg;
        if (err_latched_reg == acp_pkg::ERR_NONE)
        begin
            if (err != acp_pkg::ERR_NONE)
            begin
                err_latched_next = err;
            end
            else if (q_item.cr)
            begin
                carriage_next = 1'b1;
            end
            else
            begin
                carriage_next = 1'b0;
                recent_next   = recent_upd;
                if (q_item.lf && line_reg != 32'hffff_ffff)
                    line_next = line_reg + 32'd1;
                unique case (phase_reg)
                    acp_pkg::PH_PREFIX:
                    begin
                        if (recent_upd == prefix_reg)
                        begin
                            phase_next  = acp_pkg::PH_LOOK_NAME;
                            vertex_next = 1'b0;
                            frag_next   = 1'b0;
                        end
                    end
                    acp_pkg::PH_LOOK_NAME, acp_pkg::PH_NAME:
                    begin
                        if (q_item.ident)
                            phase_next = acp_pkg::PH_NAME;
                        else if (phase_reg == acp_pkg::PH_NAME)
                            phase_next = acp_pkg::PH_LOOK_PARAM;
                    end
                    acp_pkg::PH_LOOK_PARAM:
                    begin
                        if (q_item.ident)
                        begin
                            phase_next    = acp_pkg::PH_PARAM;
                            kw_match_next = upd_match;
                            kw_len_next   = upd_len;
                        end
                        else if (q_item.lf)
                            phase_next = acp_pkg::PH_FINAL;
                    end
                    acp_pkg::PH_PARAM:
                    begin
                        if (q_item.ident)
                        begin
                            kw_match_next = upd_match;
                            kw_len_next   = upd_len;
                        end
                        else
                        begin
                            kw_sel_next = found_k;
                            phase_next  = (found_k == acp_pkg::KW_DEFINE ||
                                           found_k == acp_pkg::KW_META) ?
                                          acp_pkg::PH_KEY : acp_pkg::PH_ENTRY;
                        end
                    end
                    acp_pkg::PH_ENTRY:
                    begin
                        if (!q_item.ident)
                        begin
                            if (sel_ps)
                                frag_next = 1'b1;
                            else
                                vertex_next = 1'b1;
                            phase_next = q_item.lf ? acp_pkg::PH_FINAL : acp_pkg::PH_LOOK_PARAM;
                        end
                    end
                    acp_pkg::PH_KEY:
                    begin
                        if (q_item.eq)
                            phase_next = acp_pkg::PH_VALUE;
                    end
                    acp_pkg::PH_VALUE:
                    begin
                        if (q_item.blank)
                            phase_next = acp_pkg::PH_LOOK_PARAM;
                        else if (q_item.lf)
                            phase_next = acp_pkg::PH_FINAL;
                    end
                    default:
                    begin
                        phase_next = acp_pkg::PH_PREFIX;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg      <= acp_pkg::PREFIX_RESET;
            phase_reg       <= acp_pkg::PH_PREFIX;
            recent_reg      <= '0;
            line_reg        <= 32'd1;
            kw_match_reg    <= 4'hf;
            kw_len_reg      <= '0;
            kw_sel_reg      <= acp_pkg::KW_DEFINE;
            vertex_reg      <= 1'b0;
            frag_reg        <= 1'b0;
            carriage_reg    <= 1'b0;
            err_latched_reg <= acp_pkg::ERR_NONE;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                prefix_reg <= cfg_data;
            if (pop)
            begin
                phase_reg       <= phase_next;
                recent_reg      <= recent_next;
                line_reg        <= line_next;
                kw_match_reg    <= kw_match_next;
                kw_len_reg      <= kw_len_next;
                kw_sel_reg      <= kw_sel_next;
                vertex_reg      <= vertex_next;
                frag_reg        <= frag_next;
                carriage_reg    <= carriage_next;
                err_latched_reg <= err_latched_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg.ev        <= ev;
            out_reg.ch        <= ch;
            out_reg.stage     <= stg;
            out_reg.pair_kind <= pk;
            out_reg.err       <= err_latched_next;
            out_reg.line      <= line_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_latched_reg != acp_pkg::ERR_NONE |=> err_latched_reg == $past(err_latched_reg))
        else $error("latched error changed");

    a_event_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.ev != acp_pkg::EV_NONE |-> out_reg.err == acp_pkg::ERR_NONE)
        else $error("event reported together with an error");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != 32'd0)
        else $error("line count wrapped");

    a_frozen_line: assert property (@(posedge clk) disable iff (!rst_n)
        err_latched_reg != acp_pkg::ERR_NONE |=> $stable(line_reg) && $stable(phase_reg))
        else $error("parser moved after an error");
`endif

endmodule

// ===== dv/tb_annotation_comment_parser_core.sv =====
module tb_annotation_comment_parser_core;
    timeunit 1ns;
    timeprecision 1ps;

    import acp_pkg::*;

    localparam int TARGET_BYTES = 1650;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 200;

    // Tracks the parser state byte by byte and queues the expected event per byte.
    class header_event_scoreboard;
        logic [31:0] prefix;
        acp_phase_t  phase;
        logic [31:0] recent;
        logic [31:0] line_no;
        logic [3:0]  kw_live;
        logic [2:0]  kw_count;
        logic [1:0]  kw_sel;
        logic        vs_seen;
        logic        ps_seen;
        logic        cr_wait;
        logic [3:0]  err_hold;
        acp_result_t expected_events[$];
        int          failures;

        function new();
            prefix   = PREFIX_RESET;
            phase    = PH_PREFIX;
            recent   = '0;
            line_no  = 32'd1;
            kw_live  = 4'hf;
            kw_count = '0;
            kw_sel   = KW_DEFINE;
            vs_seen  = 1'b0;
            ps_seen  = 1'b0;
            cr_wait  = 1'b0;
            err_hold = ERR_NONE;
            failures = 0;
        endfunction

        static function string keyword_text(logic [1:0] k);
            case (k)
                KW_DEFINE: return "define";
                KW_META:   return "meta";
                KW_VS:     return "vs";
                default:   return "ps";
            endcase
        endfunction

        static function bit is_blank(logic [7:0] c);
            return c == CH_SPACE || c == CH_TAB;
        endfunction

        static function bit is_word_byte(logic [7:0] c);
            return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                   (c >= "a" && c <= "z") || c == CH_UNDER;
        endfunction

        function void set_prefix(logic [31:0] w);
            prefix = w;
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        // drop every keyword that no longer matches; the count saturates at 7
        function void advance_keyword(logic [7:0] c);
            string kw;
            for (int k = 0; k < 4; k++)
            begin
                kw = keyword_text(2'(k));
                if (kw_count >= kw.len() || kw[kw_count] != c)
                    kw_live[k] = 1'b0;
            end
            if (kw_count < 3'd7)
                kw_count++;
        endfunction

        function void note_byte(logic [7:0] c, logic last);
            acp_result_t r;
            logic [3:0]  fault;
            int          found;
            string       kw;
            r = '0;
            r.line = line_no;
            fault = ERR_NONE;
            if (err_hold == ERR_NONE)
            begin
                if (c == CH_CR)
                begin
                    if (cr_wait || last)
                        fault = ERR_STRAY_CR;
                    else
                        cr_wait = 1'b1;
                end
                else if (cr_wait && c != CH_LF)
                begin
                    fault = ERR_STRAY_CR;
                end
                else
                begin
                    cr_wait = 1'b0;
                    if (!is_blank(c))
                        recent = {recent[23:0], c};
                    case (phase)
                        PH_PREFIX:
                        begin
                            if (recent == prefix)
                            begin
                                phase   = PH_LOOK_NAME;
                                vs_seen = 1'b0;
                                ps_seen = 1'b0;
                                r.ev    = EV_BEGIN;
                            end
                        end
                        PH_LOOK_NAME, PH_NAME:
                        begin
                            if (is_word_byte(c))
                            begin
                                phase = PH_NAME;
                                r.ev  = EV_NAME_BYTE;
                                r.ch  = c;
                            end
                            else if (is_blank(c))
                            begin
                                if (phase == PH_NAME)
                                    phase = PH_LOOK_PARAM;
                            end
                            else
                            begin
                                fault = ERR_BAD_NAME;
                            end
                        end
                        PH_LOOK_PARAM:
                        begin
                            if (is_word_byte(c))
                            begin
                                phase    = PH_PARAM;
                                kw_live  = 4'hf;
                                kw_count = '0;
                                advance_keyword(c);
                            end
                            else if (c == CH_LF)
                                phase = PH_FINAL;
                            else if (!is_blank(c))
                                fault = ERR_BAD_PARAM;
                        end
                        PH_PARAM:
                        begin
                            if (is_word_byte(c))
                            begin
                                advance_keyword(c);
                            end
                            else if (c == CH_COLON)
                            begin
                                found = -1;
                                for (int k = 0; k < 4; k++)
                                begin
                                    kw = keyword_text(2'(k));
                                    if (kw_live[k] && kw.len() == kw_count)
                                        found = k;
                                end
                                if (found < 0)
                                begin
                                    fault = ERR_UNKNOWN;
                                end
                                else
                                begin
                                    kw_sel = 2'(found);
                                    phase  = (kw_sel == KW_DEFINE || kw_sel == KW_META) ?
                                             PH_KEY : PH_ENTRY;
                                end
                            end
                            else
                            begin
                                fault = ERR_BAD_PARAM;
                            end
                        end
                        PH_ENTRY:
                        begin
                            r.stage = (kw_sel == KW_PS);
                            if (is_word_byte(c))
                            begin
                                r.ev = EV_ENTRY_BYTE;
                                r.ch = c;
                            end
                            else if (is_blank(c) || c == CH_LF)
                            begin
                                if (r.stage ? ps_seen : vs_seen)
                                begin
                                    fault = ERR_DUPLICATE;
                                end
                                else
                                begin
                                    if (r.stage)
                                        ps_seen = 1'b1;
                                    else
                                        vs_seen = 1'b1;
                                    r.ev  = EV_ENTRY_END;
                                    phase = (c == CH_LF) ? PH_FINAL : PH_LOOK_PARAM;
                                end
                            end
                            else
                            begin
                                fault = ERR_BAD_ENTRY;
                            end
                        end
                        PH_KEY:
                        begin
                            if (is_word_byte(c))
                            begin
                                r.ev        = EV_KEY_BYTE;
                                r.ch        = c;
                                r.pair_kind = (kw_sel == KW_META);
                            end
                            else if (c == CH_EQ)
                                phase = PH_VALUE;
                            else
                                fault = ERR_BAD_KEY;
                        end
                        PH_VALUE:
                        begin
                            r.pair_kind = (kw_sel == KW_META);
                            if (!is_blank(c) && c != CH_LF)
                            begin
                                r.ev = EV_VALUE_BYTE;
                                r.ch = c;
                            end
                            else
                            begin
                                r.ev  = EV_PAIR_END;
                                phase = (c == CH_LF) ? PH_FINAL : PH_LOOK_PARAM;
                            end
                        end
                        default:
                        begin
                            // first byte after the header line
                            if (!vs_seen)
                            begin
                                fault = ERR_NO_VERTEX;
                            end
                            else
                            begin
                                r.ev  = EV_HEADER_END;
                                phase = PH_PREFIX;
                            end
                        end
                    endcase
                    if (fault == ERR_NONE && c == CH_LF && line_no != 32'hffffffff)
                        line_no++;
                end
                if (fault != ERR_NONE)
                begin
                    err_hold    = fault;
                    r.ev        = EV_NONE;
                    r.ch        = '0;
                    r.stage     = 1'b0;
                    r.pair_kind = 1'b0;
                end
            end
            r.err = err_hold;
            expected_events = {expected_events, r};
        endfunction

        function void compare(string field, logic [31:0] want_v, logic [31:0] got_v);
            if (got_v !== want_v)
            begin
                $display("%0t %s mismatch: expected %0h, actual %0h", $time, field, want_v, got_v);
                failures++;
            end
        endfunction

        function void check_event(acp_result_t got);
            acp_result_t want;
            if (expected_events.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual event %0h line %0d",
                         $time, got.ev, got.line);
                failures++;
                return;
            end
            want = expected_events.pop_front();
            compare("event_res", 32'(want.ev), 32'(got.ev));
            compare("char_out", 32'(want.ch), 32'(got.ch));
            compare("stage", 32'(want.stage), 32'(got.stage));
            compare("pair_kind", 32'(want.pair_kind), 32'(got.pair_kind));
            compare("error", 32'(want.err), 32'(got.err));
            compare("line_number", want.line, got.line);
        endfunction
    endclass

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic [5:0]  m_tuser;

    header_event_scoreboard sb = new();

    logic [31:0] cur_prefix    = PREFIX_RESET;
    int          items_sent    = 0;
    int          results_taken = 0;
    int          src_calm      = 0;
    int          sink_calm     = 0;
    bit          sink_holding  = 1'b0;
    int          stall_cycles  = 0;

    annotation_comment_parser_core uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin : monitor
        acp_result_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_prefix(cfg_data);
            if (s_tvalid && s_tready)
                sb.note_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                got.ch        = m_tdata[7:0];
                got.err       = m_tdata[11:8];
                got.line      = m_tdata[43:12];
                got.ev        = m_tuser[3:0];
                got.stage     = m_tuser[4];
                got.pair_kind = m_tuser[5];
                sb.check_event(got);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("FAIL annotation_comment_parser_core");
            $finish;
        end
    end

    // idle draw per transfer, with occasional runs of back-to-back transfers
    function automatic int idle_cycles(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
        begin
            calm = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    // result sink; holds off for a long stretch twice so the input backs up
    initial
    begin
        int gap;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (results_taken == 400 || results_taken == 1200)
            begin
                m_tready     = 1'b0;
                sink_holding = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                sink_holding = 1'b0;
            end
            gap = idle_cycles(sink_calm);
            if (gap > 0)
            begin
                m_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
            results_taken++;
            @(negedge clk);
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = sink_holding ? 0 : idle_cycles(src_calm);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = b;
        s_tlast  = last;
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        items_sent++;
    endtask

    // end-of-text marker may land on any byte except a CR
    task automatic put(input logic [7:0] b);
        push_byte(b, (b != CH_CR) && ($urandom_range(0, 7) == 0));
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put(s[i]);
    endtask

    task automatic put_blanks(input int n);
        repeat (n) put($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endtask

    task automatic end_line();
        if ($urandom_range(0, 3) == 0)
            push_byte(CH_CR, 1'b0);
        put(CH_LF);
    endtask

    function automatic logic [7:0] ident_char();
        int idx;
        idx = $urandom_range(0, 62);
        if (idx < 10)
            return 8'("0" + idx);
        else if (idx < 36)
            return 8'("A" + idx - 10);
        else if (idx < 62)
            return 8'("a" + idx - 36);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] value_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR);
        return c;
    endfunction

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_LF || c == CH_CR);
        return c;
    endfunction

    // prefix bytes contain no blank, CR or LF, so nothing matches before the last one
    function automatic logic [31:0] draw_prefix();
        logic [31:0] w;
        for (int i = 0; i < 4; i++)
            w[8*i +: 8] = value_char();
        return w;
    endfunction

    task automatic filler_line();
        repeat ($urandom_range(0, 20)) put(text_char());
        end_line();
    endtask

    task automatic open_header();
        for (int i = 3; i >= 0; i--)
        begin
            put(cur_prefix[8*i +: 8]);
            if ($urandom_range(0, 5) == 0)
                put_blanks(1);
        end
    endtask

    // well-formed header: exactly one vs, at most one ps, a few define/meta pairs
    task automatic header_line();
        logic [1:0] kinds[$];
        logic [1:0] tmp;
        int         j;
        open_header();
        repeat ($urandom_range(1, 6)) put(ident_char());
        put_blanks($urandom_range(1, 2));
        kinds = {kinds, KW_VS};
        if ($urandom_range(0, 1))
            kinds = {kinds, KW_PS};
        repeat ($urandom_range(0, 3)) kinds = {kinds, ($urandom_range(0, 1) ? KW_META : KW_DEFINE)};
        for (int i = kinds.size() - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = kinds[i];
            kinds[i] = kinds[j];
            kinds[j] = tmp;
        end
        foreach (kinds[i])
        begin
            put_text(header_event_scoreboard::keyword_text(kinds[i]));
            put(CH_COLON);
            if (kinds[i] == KW_VS || kinds[i] == KW_PS)
            begin
                repeat ($urandom_range(0, 6)) put(ident_char());
            end
            else
            begin
                repeat ($urandom_range(0, 5)) put(ident_char());
                put(CH_EQ);
                repeat ($urandom_range(0, 6)) put(value_char());
            end
            if (i != kinds.size() - 1)
                put_blanks($urandom_range(1, 3));
            else if ($urandom_range(0, 1))
                put_blanks($urandom_range(1, 2));
        end
        end_line();
    endtask

    task automatic settle();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_prefix(input logic [31:0] w);
        cfg_data  = w;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid  = 1'b0;
        cur_prefix = w;
    endtask

    // errors latch until reset, so a run provokes just one of them, at the end
    task automatic provoke_error();
        filler_line();
        case ($urandom_range(0, 9))
            0:
            begin
                push_byte(CH_CR, 1'b0);
                push_byte("x", 1'b0);
            end
            1:
            begin
                push_byte(CH_CR, 1'b0);
                push_byte(CH_CR, 1'b0);
            end
            2: push_byte(CH_CR, 1'b1);
            3:
            begin
                open_header();
                put_text("#");
            end
            4:
            begin
                open_header();
                put_text("n v#");
            end
            5:
            begin
                open_header();
                put_text("n xs:");
            end
            6:
            begin
                open_header();
                put_text("n vs:a#");
            end
            7:
            begin
                open_header();
                put_text("n vs:a vs:b ");
            end
            8:
            begin
                open_header();
                put_text("n define:k#");
            end
            default:
            begin
                open_header();
                put_text("n ps:a");
                end_line();
                put("z");
            end
        endcase
        repeat (12) push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int          phase_no;
        int          phase_end;
        logic [31:0] w;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: byte extremes, end marker, then one header touching every event kind
        push_byte(8'h00, 1'b1);
        push_byte(8'hff, 1'b0);
        push_byte(CH_LF, 1'b0);
        put_text("//T:_ vs:z ps: meta:k=");
        push_byte(8'hff, 1'b0);
        push_byte(CH_CR, 1'b0);
        push_byte(CH_LF, 1'b0);
        push_byte(CH_TAB, 1'b0);

        phase_no = 0;
        while (items_sent < TARGET_BYTES)
        begin
            settle();
            case (phase_no)
                0:       w = 32'h0000_0000;
                1:       w = 32'hffff_ffff;
                2:       w = PREFIX_RESET;
                default: w = draw_prefix();
            endcase
            write_prefix(w);
            phase_end = items_sent + $urandom_range(150, 250);
            filler_line();
            while (items_sent < phase_end)
            begin
                if ($urandom_range(0, 4) < 3)
                    header_line();
                else
                    filler_line();
            end
            phase_no++;
        end

        provoke_error();
        settle();
        repeat (10) @(posedge clk);
        if (sb.failures == 0)
            $display("PASS annotation_comment_parser_core");
        else
            $display("FAIL annotation_comment_parser_core");
        $finish;
    end

endmodule

// ===== annotation_comment_parser_core.f =====
hdl/acp_pkg.sv
hdl/acp_front.sv
hdl/acp_queue.sv
hdl/acp_back.sv
hdl/annotation_comment_parser_core.sv
dv/tb_annotation_comment_parser_core.sv
